>>> src/wsg_pkg.sv
// ----------------------------------------------------------------------------
// wsg_pkg: shared types and constants for the wavetable sound generator
// Function codes, test flag bit positions and voice constants.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int NumVoices = 5;
  localparam logic [11:0] MinPitch = 12'd9;

  localparam logic [1:0] FuncWrite = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncTick  = 2'd2;
  localparam logic [1:0] FuncIdle  = 2'd3;

  // test flag bits
  localparam int TfF4       = 0;
  localparam int TfF8       = 1;
  localparam int TfResetPos = 2;
  localparam int TfRot      = 3;
  localparam int TfRot4     = 4;

  // per-voice state word kept in the voice memory
  typedef struct packed {
    logic [11:0] pitch;
    logic [11:0] counter;
    logic [4:0]  position;
    logic [3:0]  volume;
  } voice_t;

endpackage

>>> src/wavetable_sound_generator.sv
// ----------------------------------------------------------------------------
// wavetable_sound_generator: five-voice wavetable generator
// A write is decoded in a voice read step and its result loaded from the done step
// (enable, test register, plain table writes and ignored writes), or it first passes
// a voice write step (pitch and volume writes, which read-modify-write the voice
// memory, and compatible-map voice 3 table writes, which write the table twice).
// A read steps through a voice memory read for the rotate offset, a wave memory
// read, capture and output. A tick reads, updates and scales each voice in turn,
// then stores the mix: the voice word must come out of the voice memory before its
// new position can address the wave memory, and the scaled sample is added in the
// cycle after. An unused function code goes straight to the done step. One word is
// in flight at a time; the next word is accepted in the idle cycle that follows,
// and the output register lets it in while a result waits. A full output register
// stalls the result step. The wave and voice memories are cleared by a pass after
// reset, during which s_tready is low.
// ----------------------------------------------------------------------------
module wavetable_sound_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func[1:0], plus_mode[2], reg_address[10:3], write_data[18:11],
  // zero fill [23:19]
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_data[7:0], mix_out[18:8], zero fill [23:19]
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StVRd   = 4'd2;
  localparam logic [3:0] StVWr   = 4'd3;
  localparam logic [3:0] StRdA   = 4'd4;
  localparam logic [3:0] StRdB   = 4'd5;
  localparam logic [3:0] StTkA   = 4'd6;
  localparam logic [3:0] StTkB   = 4'd7;
  localparam logic [3:0] StDone  = 4'd8;
  localparam logic [3:0] StRdC   = 4'd9;
  localparam logic [3:0] StTkC   = 4'd10;
  localparam logic [3:0] StTkSum = 4'd11;

  logic        chip_variant;
  logic [3:0]  state;
  logic [7:0]  clr_addr;
  logic        plus;
  logic [7:0]  addr;
  logic [7:0]  wdat;
  logic [4:0]  test_flags;
  logic [4:0]  voice_enable;
  logic [2:0]  vidx;
  logic signed [10:0] mix_register;
  logic signed [10:0] acc;
  logic [7:0]  rd_res;
  logic        out_full;
  logic        out_load;
  logic [7:0]  out_rd;
  logic signed [10:0] out_mix;

  // memories
  localparam int NumVoicesC = wsg_pkg::NumVoices;
  wsg_pkg::voice_t vmem [NumVoicesC];
  logic [7:0]  wmem [160];
  wsg_pkg::voice_t vq;
  logic [7:0]  wq;
  logic        v_we;
  logic [2:0]  v_addr;
  wsg_pkg::voice_t v_wd;
  logic        w_we;
  logic [7:0]  w_waddr;
  logic [7:0]  w_wdat;
  logic [7:0]  w_raddr;
  wsg_pkg::voice_t cur;
  logic [4:0]  cur_pos;

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_addr] <= v_wd;
    vq <= vmem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdat;
    wq <= wmem[w_raddr];
  end

  // decode of the held word
  logic [2:0] region;
  logic [3:0] lo4;
  logic       is_tab_wr, is_ctl_wr, is_test_wr, test_rot4;
  logic       is_tab_rd;
  logic [2:0] rd_voice;
  always_comb begin
    region = addr[7:5];
    lo4 = addr[3:0];
    is_tab_wr = 1'b0; is_ctl_wr = 1'b0; is_test_wr = 1'b0; test_rot4 = 1'b0;
    is_tab_rd = 1'b0; rd_voice = region;
    if (plus) begin
      is_tab_wr = (region <= 3'd4) && !test_flags[wsg_pkg::TfRot];
      is_ctl_wr = region == 3'd5;
      is_test_wr = region == 3'd6;
      is_tab_rd = region <= 3'd4;
    end else begin
      is_tab_wr = (region <= 3'd3) && !test_flags[wsg_pkg::TfRot] &&
                  !(region == 3'd3 && test_flags[wsg_pkg::TfRot4]);
      is_ctl_wr = region == 3'd4;
      is_test_wr = (!chip_variant && region == 3'd7) || (chip_variant && region == 3'd6);
      test_rot4 = !chip_variant;
      is_tab_rd = (region <= 3'd3) || (region == 3'd5);
      if (region == 3'd5) rd_voice = 3'd4;
    end
  end

  // voice picked for a control write
  logic [2:0] ctl_voice;
  always_comb begin
    if (lo4 <= 4'd9) ctl_voice = lo4[3:1];
    else ctl_voice = 3'(lo4 - 4'hA);
  end

  // read: the offset voice for rotate
  logic [2:0] rot_src;
  logic       rot_on;
  always_comb begin
    rot_on = test_flags[wsg_pkg::TfRot];
    rot_src = rd_voice;
    if (!plus && rd_voice == 3'd3 && region == 3'd3 &&
        (test_flags[wsg_pkg::TfRot] || test_flags[wsg_pkg::TfRot4])) begin
      rot_on = 1'b1;
      rot_src = test_flags[wsg_pkg::TfRot] ? 3'd4 : 3'd3;
    end
  end

  // tick arithmetic on the voice read back
  wsg_pkg::voice_t tk;
  logic       carry;
  always_comb begin
    cur = vq;
    tk = cur;
    carry = 1'b0;
    if (cur.pitch >= wsg_pkg::MinPitch) begin
      if (test_flags[wsg_pkg::TfF4])
        tk.counter = {cur.counter[11:8] - 4'd1, cur.counter[7:0] - 8'd1};
      else
        tk.counter = cur.counter - 12'd1;
      if (test_flags[wsg_pkg::TfF8]) carry = cur.counter[7:0] == 8'd0;
      else if (test_flags[wsg_pkg::TfF4]) carry = cur.counter[11:8] == 4'd0;
      else carry = cur.counter == 12'd0;
      if (carry) begin
        tk.position = cur.position + 5'd1;
        tk.counter = cur.pitch;
      end
    end
    cur_pos = tk.position;
  end

  logic signed [12:0] prod;
  always_comb prod = $signed(wq) * $signed({1'b0, cur.volume});

  wsg_pkg::voice_t tk_q;

  // memory port control
  always_comb begin
    v_we = 1'b0; v_addr = vidx; v_wd = tk_q;
    w_we = 1'b0; w_waddr = clr_addr; w_wdat = wdat; w_raddr = 8'd0;
    unique case (state)
      StClear: begin
        w_we = 1'b1; w_wdat = 8'd0;
        // voice words are cleared in the first cycles of the pass
        v_we = clr_addr < 8'd5;
        v_addr = clr_addr[2:0];
        v_wd = '0;
      end
      StIdle: v_addr = 3'd0;
      StVRd: begin
        v_addr = ctl_voice;
        if (is_tab_wr) begin
          w_we = 1'b1;
          w_waddr = {region, addr[4:0]};
        end
      end
      StVWr: begin
        v_addr = ctl_voice;
        // only control writes change the voice word
        v_we = is_ctl_wr;
        v_wd = vq;
        if (lo4 <= 4'd9) begin
          if (test_flags[wsg_pkg::TfResetPos]) v_wd.position = 5'd0;
          if (!lo4[0]) v_wd.pitch[7:0] = wdat;
          else v_wd.pitch[11:8] = wdat[3:0];
        end else v_wd.volume = wdat[3:0];
        if (region == 3'd3 && !plus) begin
          // second copy of a shared voice 3 table write
          w_we = is_tab_wr;
          w_waddr = {3'd4, addr[4:0]};
        end
      end
      StRdA: v_addr = rot_src;
      StRdB: w_raddr = {rd_voice, addr[4:0] + (rot_on ? vq.position : 5'd0)};
      StTkA: v_addr = vidx;
      StTkB: begin
        v_addr = vidx;
        v_we = 1'b1;
        v_wd = tk;
        w_raddr = {vidx, cur_pos};
      end
      default: ;
    endcase
  end

  // output register load
  assign out_load = (state == StDone) && (!out_full || m_tready);

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      clr_addr <= 8'd0;
      test_flags <= 5'd0;
      voice_enable <= 5'd0;
      mix_register <= '0;
      out_full <= 1'b0;
      chip_variant <= 1'b0;
      vidx <= 3'd0;
      acc <= '0;
    end else begin
      if (cfg_we) chip_variant <= cfg_wdata;
      if (out_load) out_full <= 1'b1;
      else if (m_tvalid && m_tready) out_full <= 1'b0;
      unique case (state)
        StClear: begin
          clr_addr <= clr_addr + 8'd1;
          if (clr_addr == 8'd159) state <= StIdle;
        end
        StIdle: if (s_tvalid && s_tready) begin
          plus <= s_tdata[2] && chip_variant;
          addr <= s_tdata[10:3];
          wdat <= s_tdata[18:11];
          rd_res <= 8'd0;
          vidx <= 3'd0;
          acc <= '0;
          unique case (s_tdata[1:0])
            wsg_pkg::FuncWrite: state <= StVRd;
            wsg_pkg::FuncRead:  state <= StRdA;
            wsg_pkg::FuncTick:  state <= StTkA;
            default:            state <= StDone;
          endcase
        end
        StVRd: begin
          state <= StDone;
          if (is_ctl_wr) begin
            if (lo4 == 4'hF) voice_enable <= wdat[4:0];
            else state <= StVWr;
          end else if (is_test_wr) begin
            test_flags[3:0] <= {wdat[6], wdat[5], wdat[1], wdat[0]};
            if (test_rot4) test_flags[wsg_pkg::TfRot4] <= wdat[7];
          end else if (is_tab_wr && !plus && region == 3'd3) state <= StVWr;
        end
        StVWr: state <= StDone;
        StRdA: begin
          if (is_tab_rd) state <= StRdB;
          else begin
            rd_res <= 8'hFF;
            state <= StDone;
          end
        end
        StRdB: state <= StRdC;
        StTkA: state <= StTkB;
        StTkB: begin
          tk_q <= tk;
          state <= StTkC;
        end
        StTkC: begin
          if (voice_enable[vidx]) acc <= acc + 11'(prod >>> 4);
          if (vidx == 3'd4) state <= StTkSum;
          else begin
            vidx <= vidx + 3'd1;
            state <= StTkA;
          end
        end
        StTkSum: begin
          mix_register <= acc;
          state <= StDone;
        end
        StRdC: begin
          rd_res <= wq;
          state <= StDone;
        end
        StDone: if (out_load) begin
          out_rd <= rd_res;
          out_mix <= mix_register;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign s_tready = (state == StIdle);
  assign m_tvalid = out_full;
  assign m_tdata  = {5'd0, out_mix, out_rd};

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == StClear) |-> !s_tready) else $error("accept during clear");
  a_tick_voice_range: assert property (@(posedge clk) disable iff (rst)
    (state == StTkA) |-> (vidx <= 3'd4)) else $error("voice index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("output changed");

endmodule

>>> tb/wavetable_sound_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wavetable_sound_generator_test: self-checking bench for the sound generator
// Streams register writes, reads and sample ticks into the block, predicts
// every read byte and mix value with an in-bench voice model, and compares
// each output word against the oldest prediction. Both chip variants and
// both register maps are exercised, with random gaps on both sides.
// ----------------------------------------------------------------------------
module wavetable_sound_generator_test;

  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [7:0] wdata;
    logic [7:0] addr;
    logic       plus;
    logic [1:0] func;
  } cmd_t;

  typedef struct packed {
    logic [10:0] mix;
    logic [7:0]  rdata;
  } snd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  wavetable_sound_generator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic        variant;
  logic [7:0]  wave [160];
  logic [11:0] pitch [wsg_pkg::NumVoices];
  logic [3:0]  vol [wsg_pkg::NumVoices];
  logic        ena [wsg_pkg::NumVoices];
  logic [4:0]  pos [wsg_pkg::NumVoices];
  logic [11:0] cnt [wsg_pkg::NumVoices];
  logic [4:0]  tflags;
  logic [10:0] mix;

  cmd_t cmd_queue[$];
  snd_t sound_expect[$];
  int   errors = 0;
  int   idle_cycles = 0;

  function automatic void set_test(logic [7:0] d, bit with_rot4);
    logic [4:0] f;
    f = {1'b0, d[6], d[5], d[1], d[0]};
    f[wsg_pkg::TfRot4] = with_rot4 ? d[7] : tflags[wsg_pkg::TfRot4];
    tflags = f;
  endfunction

  function automatic void wave_write(bit plus, logic [7:0] a, logic [7:0] d);
    int v;
    v = int'(a[7:5]);
    if (tflags[wsg_pkg::TfRot] || v > 4) return;
    if (!plus) begin
      if (v == 4 || (v == 3 && tflags[wsg_pkg::TfRot4])) return;
      if (v == 3) wave[128 + int'(a[4:0])] = d;
    end
    wave[v * 32 + int'(a[4:0])] = d;
  endfunction

  function automatic logic [7:0] wave_read(bit plus, int v, logic [4:0] i);
    logic [4:0] k;
    k = i;
    if (tflags[wsg_pkg::TfRot]) k = i + pos[v];
    if (!plus && v == 3 && (tflags[wsg_pkg::TfRot] || tflags[wsg_pkg::TfRot4]))
      k = i + pos[tflags[wsg_pkg::TfRot] ? 4 : 3];
    return wave[v * 32 + int'(k)];
  endfunction

  function automatic void voice_write(logic [7:0] a, logic [7:0] d);
    int n;
    n = int'(a[3:1]);
    if (a[3:0] <= 4'd9) begin
      if (tflags[wsg_pkg::TfResetPos]) pos[n] = '0;
      if (!a[0]) pitch[n][7:0] = d;
      else pitch[n][11:8] = d[3:0];
    end else if (a[3:0] <= 4'he) begin
      vol[a[3:0] - 4'ha] = d[3:0];
    end else begin
      for (int k = 0; k < wsg_pkg::NumVoices; k++) ena[k] = d[k];
    end
  endfunction

  function automatic void tick_voices();
    logic [11:0] old;
    logic signed [15:0] p;
    logic signed [11:0] sum;
    bit carry;
    sum = '0;
    for (int v = 0; v < wsg_pkg::NumVoices; v++) begin
      if (pitch[v] >= wsg_pkg::MinPitch) begin
        old = cnt[v];
        if (tflags[wsg_pkg::TfF4]) cnt[v] = {old[11:8] - 4'd1, old[7:0] - 8'd1};
        else cnt[v] = old - 12'd1;
        if (tflags[wsg_pkg::TfF8]) carry = (old[7:0] == 8'd0);
        else if (tflags[wsg_pkg::TfF4]) carry = (old[11:8] == 4'd0);
        else carry = (old == 12'd0);
        if (carry) begin
          pos[v] = pos[v] + 5'd1;
          cnt[v] = pitch[v];
        end
      end
      if (ena[v]) begin
        p = $signed(wave[v * 32 + int'(pos[v])]) * $signed({1'b0, vol[v]});
        sum = 12'(sum + (p >>> 4));
      end
    end
    mix = sum[10:0];
  endfunction

  function automatic snd_t predict_sound(cmd_t c);
    snd_t r;
    bit pl;
    int rg;
    pl = variant && c.plus;
    rg = int'(c.addr[7:5]);
    r.rdata = '0;
    if (c.func == wsg_pkg::FuncWrite) begin
      if (pl) begin
        if (rg <= 4) wave_write(1'b1, c.addr, c.wdata);
        else if (rg == 5) voice_write(c.addr, c.wdata);
        else if (rg == 6) set_test(c.wdata, 1'b0);
      end else begin
        if (rg <= 3) wave_write(1'b0, c.addr, c.wdata);
        else if (rg == 4) voice_write(c.addr, c.wdata);
        else if (!variant && rg == 7) set_test(c.wdata, 1'b1);
        else if (variant && rg == 6) set_test(c.wdata, 1'b0);
      end
    end else if (c.func == wsg_pkg::FuncRead) begin
      r.rdata = 8'hff;
      if (pl) begin
        if (rg <= 4) r.rdata = wave_read(1'b1, rg, c.addr[4:0]);
      end else if (rg <= 3) r.rdata = wave_read(1'b0, rg, c.addr[4:0]);
      else if (rg == 5) r.rdata = wave_read(1'b0, 4, c.addr[4:0]);
    end else if (c.func == wsg_pkg::FuncTick) begin
      tick_voices();
    end
    r.mix = mix;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic cmd_t mk(logic [1:0] f, bit pl, logic [7:0] a, logic [7:0] d);
    cmd_t c;
    c.func = f; c.plus = pl; c.addr = a; c.wdata = d;
    return c;
  endfunction

  // random item, biased toward meaningful traffic
  function automatic cmd_t rand_cmd(bit plus_bias);
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c.plus = plus_bias ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
    c.wdata = 8'($urandom);
    c.addr = 8'($urandom);
    if (r < 40) c.func = wsg_pkg::FuncTick;
    else if (r < 65) c.func = wsg_pkg::FuncRead;
    else if (r < 98) c.func = wsg_pkg::FuncWrite;
    else c.func = wsg_pkg::FuncIdle;
    if (c.func == wsg_pkg::FuncWrite && $urandom_range(0, 2) == 0) begin
      // voice registers, test register rarely
      c.addr[7:5] = (variant && c.plus) ? 3'd5 : 3'd4;
      if ($urandom_range(0, 4) == 0) begin
        c.addr[7:5] = variant ? 3'd6 : 3'd7;
        c.wdata[7:6] = ($urandom_range(0, 2) == 0) ? 2'($urandom) : 2'b00;
      end
      if (c.addr[3:0] <= 4'd9 && c.addr[0] && $urandom_range(0, 1) != 0)
        c.wdata[3:0] = 4'd0;
      if (c.addr[3:0] <= 4'd9 && !c.addr[0] && $urandom_range(0, 2) == 0)
        c.wdata = 8'($urandom_range(0, 20));
    end
    return c;
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sound_expect.push_back(predict_sound(cmd_t'(s_tdata[18:0])));
      void'(cmd_queue.pop_front());
    end
    if (!rst && (!s_tvalid || s_tready)) begin
      if (s_tvalid && s_tready) src_gap = gap_len();
      if (src_gap > 0 || cmd_queue.size() == 0) begin
        if (src_gap > 0) src_gap = src_gap - 1;
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, cmd_queue[0]};
      end
    end
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk) begin
    snd_t got, want;
    if (m_tvalid && m_tready) begin
      got = m_tdata[18:0];
      if (sound_expect.size() == 0) begin
        $error("unexpected word %h", m_tdata);
        errors++;
      end else begin
        want = sound_expect.pop_front();
        if (got.rdata !== want.rdata) begin
          $error("read_data expected %h got %h", want.rdata, got.rdata);
          errors++;
        end
        if (got.mix !== want.mix) begin
          $error("mix_out expected %0d got %0d", $signed(want.mix), $signed(got.mix));
          errors++;
        end
      end
    end
    if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap = gap_len();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (cmd_queue.size() != 0 || s_tvalid || sound_expect.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_variant(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    variant = v;
  endtask

  task automatic run_random(int n, bit plus_bias);
    for (int k = 0; k < n; k++) begin
      cmd_queue.push_back(rand_cmd(plus_bias));
      if (k % 50 == 49) while (cmd_queue.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    variant = 1'b0;
    foreach (wave[k]) wave[k] = '0;
    for (int v = 0; v < wsg_pkg::NumVoices; v++) begin
      pitch[v] = '0; vol[v] = '0; ena[v] = 1'b0; pos[v] = '0; cnt[v] = '0;
    end
    tflags = '0;
    mix = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_variant(1'b0);

    // directed: extremes of samples, volumes, pitches, compatible-map corners
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h00, 8'h80));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h7f, 8'h7f));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b1, 8'h61, 8'hff));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h8a, 8'hff));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h8d, 8'h0f));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h8f, 8'hff));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h80, 8'h09));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h87, 8'h08));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h86, 8'h08));
    cmd_queue.push_back(mk(wsg_pkg::FuncTick, 1'b0, 8'h00, 8'h00));
    cmd_queue.push_back(mk(wsg_pkg::FuncRead, 1'b0, 8'ha1, 8'h00));
    cmd_queue.push_back(mk(wsg_pkg::FuncRead, 1'b0, 8'hff, 8'h00));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'hff, 8'he3));
    for (int k = 0; k < 4; k++)
      cmd_queue.push_back(mk(wsg_pkg::FuncTick, 1'b0, 8'h00, 8'h00));
    cmd_queue.push_back(mk(wsg_pkg::FuncRead, 1'b0, 8'h61, 8'h00));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h60, 8'h55));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'h80, 8'hff));
    cmd_queue.push_back(mk(wsg_pkg::FuncIdle, 1'b1, 8'hff, 8'hff));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b0, 8'he0, 8'h00));
    cmd_queue.push_back(mk(wsg_pkg::FuncTick, 1'b0, 8'h00, 8'h00));
    drain();  // sender pauses until all results are back

    run_random(300, 1'b0);
    drain();
    set_variant(1'b1);
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b1, 8'hc0, 8'hff));
    cmd_queue.push_back(mk(wsg_pkg::FuncWrite, 1'b1, 8'hbf, 8'h1f));
    cmd_queue.push_back(mk(wsg_pkg::FuncRead, 1'b1, 8'h9f, 8'h00));
    run_random(450, 1'b1);
    drain();
    set_variant(1'b0);
    run_random(250, 1'b0);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
